/* sv/secu_pkg.sv */
// Shared types and constants for the smooth escape-time coloring unit.
// Used by the log2 unit, the colormap and the top level; depends on nothing.
package secu_pkg;

    // Action codes of an input transaction.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    // Fraction bits of the squared modulus and of log2|z|.
    localparam int SQ_FRAC_BITS  = 56;
    localparam int LOG_FRAC_BITS = 16;

    // Number of squaring steps in the log2 unit (one result bit each).
    localparam int LOG_STEPS = 16;

    // Width of the RGB888 color and of one channel.
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;

    // Width of the offset floor count used for the table index.
    localparam int BASE_W = 18;

    // Sideband carried through the pipeline with each transaction.
    typedef struct packed {
        logic                pix;
        logic                in_set;
        logic signed [16:0]  n;
        logic                s_zero;
        logic [7:0]          entry_index;
        logic [COLOR_W-1:0]  entry_color;
    } t_side;

endpackage

/* sv/secu_log2.sv */
// Pipelined fixed-point log2 unit: one normalize stage and one squaring stage per result bit.
// Depends on secu_pkg for the sideband type and the step count.
module secu_log2 (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [63:0]           i_val,
    input  secu_pkg::t_side       i_side,
    output logic                  o_vld,
    output logic [5:0]            o_msb,
    output logic [15:0]           o_frac,
    output secu_pkg::t_side       o_side
);
    localparam int NS = secu_pkg::LOG_STEPS + 1;

    logic            r_vld  [NS];
    logic [31:0]     r_m    [NS];
    logic [15:0]     r_f    [NS];
    logic [5:0]      r_p    [NS];
    secu_pkg::t_side r_sd   [NS];

    logic [5:0]      n_p;
    logic [31:0]     n_m0;
    logic [31:0]     n_m    [NS];
    logic            n_bit  [NS];
    logic [63:0]     w_sq   [NS];

    // Leading one search and normalization to Q1.31.
    always_comb begin
        n_p = 6'd0;
        for (int i = 1; i < 64; i++) begin
            if (i_val[i]) begin
                n_p = 6'(i);
            end
        end
        if (n_p >= 6'd31) begin
            n_m0 = 32'(i_val >> (n_p - 6'd31));
        end else begin
            n_m0 = 32'(i_val << (6'd31 - n_p));
        end
    end

    // One squaring per stage; the mantissa is renormalized when it reaches two.
    always_comb begin
        n_m[0]   = '0;
        n_bit[0] = 1'b0;
        w_sq[0]  = '0;
        for (int k = 1; k < NS; k++) begin
            w_sq[k]  = 64'(r_m[k-1]) * 64'(r_m[k-1]);
            n_bit[k] = w_sq[k][63];
            n_m[k]   = w_sq[k][63] ? w_sq[k][63:32] : w_sq[k][62:31];
        end
    end

    // Stage registers; every stage moves together on the pipeline enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]  <= n_m0;
            r_f[0]  <= '0;
            r_p[0]  <= n_p;
            r_sd[0] <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_m[k]  <= n_m[k];
                r_f[k]  <= {r_f[k-1][14:0], n_bit[k]};
                r_p[k]  <= r_p[k-1];
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_msb  = r_p[NS-1];
    assign o_frac = r_f[NS-1];
    assign o_side = r_sd[NS-1];

endmodule

/* sv/secu_cmap.sv */
// Colormap memory: one write port and two registered read ports.
// Depends on secu_pkg for the color width.
module secu_cmap #(
    parameter int SIZE = 256
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic                           i_we,
    input  logic [$clog2(SIZE)-1:0]        i_waddr,
    input  logic [secu_pkg::COLOR_W-1:0]   i_wdata,
    input  logic [$clog2(SIZE)-1:0]        i_raddr0,
    input  logic [$clog2(SIZE)-1:0]        i_raddr1,
    output logic [secu_pkg::COLOR_W-1:0]   o_rdata0,
    output logic [secu_pkg::COLOR_W-1:0]   o_rdata1
);
    logic [secu_pkg::COLOR_W-1:0] r_mem [SIZE];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two read ports with registered data, held while the pipeline stalls.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

/* sv/smooth_escape_time_coloring_unit.sv */
// Smooth escape-time coloring unit. Accepts one transaction per cycle unless stalled and
// returns one color per pixel transaction; colormap write transactions give no result.
// The pipeline holds two 17-stage log2 units, each a normalize stage followed by
// 16 stages of one 32x32 squaring.
// The whole pipeline advances together and holds while a finished color waits to be taken.
// Depends on secu_pkg, secu_log2 and secu_cmap.
module smooth_escape_time_coloring_unit #(
    parameter int COLORMAP_SIZE = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [7:0]                    i_entry_index,
    input  logic [23:0]                   i_entry_color,
    input  logic signed [16:0]            i_iteration_count,
    input  logic signed [31:0]            i_escape_re,
    input  logic signed [31:0]            i_escape_im,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [23:0]                   o_pixel_color,
    input  logic                          i_cfg_we,
    input  logic [23:0]                   i_cfg_wdata
);
    localparam int IW = (COLORMAP_SIZE > 1) ? $clog2(COLORMAP_SIZE) : 1;
    localparam int BW = secu_pkg::BASE_W;
    localparam longint OFFS = longint'(COLORMAP_SIZE)
                              * ((longint'(131072) + COLORMAP_SIZE - 1) / COLORMAP_SIZE);
    localparam logic [31:0] RECIP =
        32'(((longint'(1) <<< 32) + COLORMAP_SIZE - 1) / COLORMAP_SIZE);

    logic en;
    logic r_out_vld;
    logic [23:0] r_out;
    logic [23:0] r_in_set_color;

    // Pipeline enable: advance unless a finished color is stalled.
    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_vld;
    assign o_pixel_color = r_out;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_set_color <= '0;
        end else if (i_cfg_we) begin
            r_in_set_color <= i_cfg_wdata;
        end
    end

    // Stage 1: capture and take absolute values.
    secu_pkg::t_side n_sd1;
    logic r_v1, r_v2, r_v3;
    secu_pkg::t_side r_sd1, r_sd2, r_sd3;
    logic [31:0] r_ax, r_ay;
    logic [63:0] r_sqx, r_sqy, r_s;

    always_comb begin
        n_sd1.pix         = (i_action == secu_pkg::ACT_PIXEL);
        n_sd1.in_set      = (i_iteration_count == -17'sd1);
        n_sd1.n           = i_iteration_count;
        n_sd1.s_zero      = 1'b0;
        n_sd1.entry_index = i_entry_index;
        n_sd1.entry_color = i_entry_color;
    end

    // Stages 1 to 3: absolute values, squares, squared modulus.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd1 <= n_sd1;
            r_ax  <= i_escape_re[31] ? (~i_escape_re + 32'd1) : i_escape_re;
            r_ay  <= i_escape_im[31] ? (~i_escape_im + 32'd1) : i_escape_im;
            r_sd2 <= r_sd1;
            r_sqx <= 64'(r_ax) * 64'(r_ax);
            r_sqy <= 64'(r_ay) * 64'(r_ay);
            r_sd3 <= r_sd2;
            r_s   <= r_sqx + r_sqy;
        end
    end

    // First log2: log2 of the squared modulus.
    secu_pkg::t_side n_sdA, a_sd;
    logic a_vld;
    logic [5:0] a_p;
    logic [15:0] a_f;

    always_comb begin
        n_sdA        = r_sd3;
        n_sdA.s_zero = (r_s == 64'd0);
    end

    secu_log2 u_log_a (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_v3),
        .i_val  (r_s),
        .i_side (n_sdA),
        .o_vld  (a_vld),
        .o_msb  (a_p),
        .o_frac (a_f),
        .o_side (a_sd)
    );

    // Halve to log2|z| and clamp to the smallest positive value.
    logic signed [7:0]  n_l2i;
    logic signed [23:0] n_l2, n_lzf;
    logic [17:0] n_lz, r_lz;
    logic r_vL;
    secu_pkg::t_side r_sdL;

    always_comb begin
        n_l2i = $signed({2'b00, a_p}) - 8'sd56;
        n_l2  = {n_l2i, a_f};
        n_lzf = n_l2 >>> 1;
        if (a_sd.s_zero || n_lzf[23] || (n_lzf == 24'sd0)) begin
            n_lz = 18'd1;
        end else begin
            n_lz = n_lzf[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vL <= 1'b0;
        end else if (en) begin
            r_vL <= a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lz  <= n_lz;
            r_sdL <= a_sd;
        end
    end

    // Second log2: log2 of log2|z|.
    secu_pkg::t_side b_sd;
    logic b_vld;
    logic [5:0] b_p;
    logic [15:0] b_f;

    secu_log2 u_log_b (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_vL),
        .i_val  (64'(r_lz)),
        .i_side (r_sdL),
        .o_vld  (b_vld),
        .o_msb  (b_p),
        .o_frac (b_f),
        .o_side (b_sd)
    );

    // Smoothed count, floor split and offset into non-negative range.
    logic signed [6:0]  n_nui;
    logic signed [22:0] n_nu;
    logic signed [17:0] n_n1;
    logic signed [34:0] n_mu;
    logic signed [19:0] n_vs;
    logic r_vM;
    secu_pkg::t_side r_sdM;
    logic [BW-1:0] r_vv;
    logic [7:0] r_f8M;

    always_comb begin
        n_nui = $signed({1'b0, b_p}) - 7'sd16;
        n_nu  = {n_nui, b_f};
        n_n1  = {b_sd.n[16], b_sd.n} + 18'sd1;
        n_mu  = {n_n1[17], n_n1, 16'b0} - {{12{n_nu[22]}}, n_nu};
        n_vs  = {n_mu[34], n_mu[34:16]} + 20'(OFFS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vM <= 1'b0;
        end else if (en) begin
            r_vM <= b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sdM <= b_sd;
            r_vv  <= n_vs[BW-1:0];
            r_f8M <= n_mu[15:8];
        end
    end

    // Quotient by reciprocal multiplication, then remainder and next index.
    logic [BW+31:0] n_qp;
    logic [BW-1:0] r_q, r_vvQ;
    logic [BW+12:0] n_qs;
    logic [IW-1:0] n_idx;
    logic r_vQ, r_vR;
    secu_pkg::t_side r_sdQ, r_sdR;
    logic [7:0] r_f8Q, r_f8R;
    logic [IW-1:0] r_idx, r_idx1;

    assign n_qp  = (BW+32)'(r_vv) * (BW+32)'(RECIP);
    assign n_qs  = (BW+13)'(r_vvQ) - (BW+13)'(r_q) * (BW+13)'(COLORMAP_SIZE);
    assign n_idx = n_qs[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vQ <= 1'b0;
            r_vR <= 1'b0;
        end else if (en) begin
            r_vQ <= r_vM;
            r_vR <= r_vQ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sdQ  <= r_sdM;
            r_q    <= n_qp[BW+31:32];
            r_vvQ  <= r_vv;
            r_f8Q  <= r_f8M;
            r_sdR  <= r_sdQ;
            r_f8R  <= r_f8Q;
            r_idx  <= n_idx;
            r_idx1 <= (n_idx == IW'(COLORMAP_SIZE - 1)) ? '0 : n_idx + IW'(1);
        end
    end

    // Colormap: writes and reads happen at the same stage, keeping transaction order.
    logic n_we;
    logic [23:0] w_c1, w_c2;
    logic r_vC;
    secu_pkg::t_side r_sdC;
    logic [7:0] r_f8C;

    assign n_we = r_vR && !r_sdR.pix
                  && (32'(r_sdR.entry_index) < 32'(COLORMAP_SIZE));

    secu_cmap #(.SIZE(COLORMAP_SIZE)) u_cmap (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (n_we),
        .i_waddr (IW'(r_sdR.entry_index)),
        .i_wdata (r_sdR.entry_color),
        .i_raddr0(r_idx),
        .i_raddr1(r_idx1),
        .o_rdata0(w_c1),
        .o_rdata1(w_c2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vC <= 1'b0;
        end else if (en) begin
            r_vC <= r_vR && r_sdR.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sdC <= r_sdR;
            r_f8C <= r_f8R;
        end
    end

    // Blend products per channel.
    logic signed [17:0] n_pr [3];
    logic signed [17:0] r_pr [3];
    logic signed [8:0]  n_d  [3];
    logic [23:0] r_c1;
    logic r_vB, r_inB;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_d[c]  = $signed({1'b0, w_c2[c*8 +: 8]}) - $signed({1'b0, w_c1[c*8 +: 8]});
            n_pr[c] = 18'(n_d[c] * $signed({1'b0, r_f8C}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vB <= 1'b0;
        end else if (en) begin
            r_vB <= r_vC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1  <= w_c1;
            r_inB <= r_sdC.in_set;
            for (int c = 0; c < 3; c++) begin
                r_pr[c] <= n_pr[c];
            end
        end
    end

    // Divide by 256 toward zero, add to the first color, pick the in-set color.
    logic signed [17:0] n_tq [3];
    logic [23:0] n_out;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_tq[c] = r_pr[c][17] ? ((r_pr[c] + 18'sd255) >>> 8) : (r_pr[c] >>> 8);
            n_out[c*8 +: 8] = r_c1[c*8 +: 8] + n_tq[c][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= r_inB ? r_in_set_color : n_out;
        end
    end

endmodule

/* sv/secu_checker.sv */
// Port-level checks for the smooth escape-time coloring unit, bound to the top level.
// Depends only on the top level's ports.
module secu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [23:0] o_pixel_color
);
    // A stalled color stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_color))
        else $error("stalled color changed");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Input side is ready exactly when the output register can move.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready does not follow the output stall");

endmodule

bind smooth_escape_time_coloring_unit secu_checker u_secu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_pixel_color(o_pixel_color)
);

/* tb/sv/tb_smooth_escape_time_coloring_unit.sv */
// Testbench for the smooth escape-time coloring unit: random and directed pixel and colormap
// transactions, checked against a built-in predictor of the smoothed-count coloring.
// Depends on secu_pkg and smooth_escape_time_coloring_unit.
`timescale 1ns / 100ps

module tb_smooth_escape_time_coloring_unit;

    typedef struct {
        logic               action;
        logic [7:0]         entry_index;
        logic [23:0]        entry_color;
        logic signed [16:0] iteration_count;
        logic signed [31:0] escape_re;
        logic signed [31:0] escape_im;
    } t_item;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_action = secu_pkg::ACT_WRITE;
    logic [7:0]         i_entry_index = '0;
    logic [23:0]        i_entry_color = '0;
    logic signed [16:0] i_iteration_count = '0;
    logic signed [31:0] i_escape_re = '0;
    logic signed [31:0] i_escape_im = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [23:0]        o_pixel_color;
    logic               i_cfg_we = 1'b0;
    logic [23:0]        i_cfg_wdata = '0;

    t_item       pending_items[$];
    logic [23:0] expected_colors[$];
    logic [23:0] cmap_copy[256];
    logic [23:0] in_set_copy = '0;
    bit          calm = 1'b0;
    int          error_count = 0;

    smooth_escape_time_coloring_unit #(.COLORMAP_SIZE(256)) DUT (.*);

    always #1 i_clk = ~i_clk;

    // Fixed-point log2 of v with fb fraction bits; result carries 16 fraction bits.
    function automatic longint log2_q16(logic [63:0] v, int fb);
        int          p;
        logic [63:0] m;
        longint      frac;
        p = 63;
        frac = 0;
        while (p > 0 && !v[p]) p--;
        m = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
        for (int i = 0; i < secu_pkg::LOG_STEPS; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return longint'(p - fb) * 65536 + frac;
    endfunction

    // Linear blend of one channel, truncated toward zero.
    function automatic logic [7:0] blend_chan(logic [7:0] a, logic [7:0] b, longint f8);
        longint d;
        d = longint'(b) - longint'(a);
        return 8'(longint'(a) + (d * f8) / 256);
    endfunction

    // Smoothed escape-time color of one pixel.
    function automatic logic [23:0] pixel_shade(t_item it);
        logic [63:0] ax, ay, s;
        longint      l2, lz, nu, mu, f8;
        logic [7:0]  idx;
        logic [23:0] c1, c2;
        if (it.iteration_count == -17'sd1) return in_set_copy;
        ax = (it.escape_re < 0) ? 64'(-longint'(it.escape_re)) : 64'(it.escape_re);
        ay = (it.escape_im < 0) ? 64'(-longint'(it.escape_im)) : 64'(it.escape_im);
        s = ax * ax + ay * ay;
        if (s == 0) begin
            lz = 1;
        end else begin
            l2 = log2_q16(s, secu_pkg::SQ_FRAC_BITS);
            lz = l2 >>> 1;
            if (lz < 1) lz = 1;
        end
        nu = log2_q16(64'(lz), secu_pkg::LOG_FRAC_BITS);
        mu = (longint'(it.iteration_count) + 1) * 65536 - nu;
        idx = 8'(mu >>> 16);
        f8 = (mu & 64'hFFFF) >> 8;
        c1 = cmap_copy[idx];
        c2 = cmap_copy[8'(idx + 1)];
        return {blend_chan(c1[23:16], c2[23:16], f8), blend_chan(c1[15:8], c2[15:8], f8),
                blend_chan(c1[7:0], c2[7:0], f8)};
    endfunction

    function automatic t_item make_pixel(int n, int re, int im);
        t_item it;
        it.action = secu_pkg::ACT_PIXEL;
        it.entry_index = 8'($urandom);
        it.entry_color = 24'($urandom);
        it.iteration_count = 17'(n);
        it.escape_re = re;
        it.escape_im = im;
        return it;
    endfunction

    function automatic t_item make_write(int idx, int col);
        t_item it;
        it = make_pixel($urandom_range(131071), $urandom, $urandom);
        it.action = secu_pkg::ACT_WRITE;
        it.entry_index = 8'(idx);
        it.entry_color = 24'(col);
        return it;
    endfunction

    // Random transaction: mostly pixels with escape-like magnitudes, some writes.
    function automatic t_item random_item();
        int r, n, re, im;
        r = $urandom_range(99);
        if (r < 15) return make_write($urandom_range(255), $urandom);
        n = (r < 22) ? -1 : (r < 30) ? -int'($urandom_range(65536)) : $urandom_range(65535);
        re = $urandom;
        im = $urandom;
        if ($urandom_range(1)) begin
            re = re >>> $urandom_range(31);
            im = im >>> $urandom_range(31);
        end
        return make_pixel(n, re, im);
    endfunction

    // Driver: presents queued transactions, mirrors accepted colormap writes and predicts each accepted pixel.
    always @(posedge i_clk) begin
        t_item nxt;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                if (i_action == secu_pkg::ACT_WRITE) begin
                    cmap_copy[i_entry_index] = i_entry_color;
                end else begin
                    nxt.action = i_action;
                    nxt.entry_index = i_entry_index;
                    nxt.entry_color = i_entry_color;
                    nxt.iteration_count = i_iteration_count;
                    nxt.escape_re = i_escape_re;
                    nxt.escape_im = i_escape_im;
                    expected_colors.push_back(pixel_shade(nxt));
                end
            end
            if (!i_valid || o_ready) begin
                if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
                    nxt = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_action <= nxt.action;
                    i_entry_index <= nxt.entry_index;
                    i_entry_color <= nxt.entry_color;
                    i_iteration_count <= nxt.iteration_count;
                    i_escape_re <= nxt.escape_re;
                    i_escape_im <= nxt.escape_im;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and in-order check of each color.
    always @(posedge i_clk) begin
        logic [23:0] want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_colors.size() == 0) begin
                    $error("pixel_color: expected none, got %06h", o_pixel_color);
                    error_count++;
                end else begin
                    want = expected_colors.pop_front();
                    if (o_pixel_color !== want) begin
                        $error("pixel_color: expected %06h, got %06h", want, o_pixel_color);
                        error_count++;
                    end
                end
            end
            i_ready <= calm || ($urandom_range(99) >= 28);
        end
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || i_valid || expected_colors.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_in_set(logic [23:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        in_set_copy = v;
    endtask

    // Stimulus: table fill, directed corners, then random phases under several in-set colors.
    initial begin
        logic [23:0] settings[3];
        settings = '{24'hFFFFFF, 24'h000000, 24'($urandom)};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_in_set(24'h5A3C96);
        for (int i = 0; i < 256; i++) pending_items.push_back(make_write(i, $urandom));
        pending_items.push_back(make_pixel(-1, 0, 0));
        pending_items.push_back(make_pixel(0, 0, 0));
        pending_items.push_back(make_pixel(65535, 0, 0));
        pending_items.push_back(make_pixel(-65536, 0, 0));
        pending_items.push_back(make_pixel(-2, 1, 0));
        pending_items.push_back(make_pixel(-3, 32'h7FFFFFFF, 32'h7FFFFFFF));
        pending_items.push_back(make_pixel(65535, 32'h80000000, 32'h80000000));
        pending_items.push_back(make_pixel(10, 32'h10000000, 0));
        pending_items.push_back(make_pixel(255, 32'h20000000, 32'hE0000000));
        pending_items.push_back(make_pixel(100, 0, 32'h00010000));
        pending_items.push_back(make_write(255, 24'hFFFFFF));
        pending_items.push_back(make_write(0, 24'h000000));
        pending_items.push_back(make_pixel(254, 32'h7FFFFFFF, 0));
        pending_items.push_back(make_pixel(-258, 32'h30000000, 32'h30000000));
        pending_items.push_back(make_pixel(-1, 32'h80000000, 32'h7FFFFFFF));
        wait_idle();
        for (int ph = 0; ph < 3; ph++) begin
            write_in_set(settings[ph]);
            for (int k = 0; k < 510; k++) pending_items.push_back(random_item());
            if (ph == 1) begin
                calm = 1'b1;
                while (pending_items.size() > 255) @(posedge i_clk);
                calm = 1'b0;
            end
            wait_idle();
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
